[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ESF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define ESF_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");
`else
`define ESF_ASSERT(lbl, clk, rst_n, prop)
`define ESF_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[sv/esf_pkg.sv]
// ----------------------------------------------------------------------------
// esf_pkg
// Shared types, constants and microcode for the envelope smoothing filter.
// ----------------------------------------------------------------------------
package esf_pkg;

	localparam int VAL_W     = 16;
	localparam int IDX_W     = 10;
	localparam int PASS_W    = 8;
	localparam int ACC_W     = 24;
	localparam int DIV_W     = 9;
	localparam int RCP_W     = 25;
	localparam int RCP_SHIFT = 33;
	localparam int PROD_W    = ACC_W + RCP_W;
	localparam int NUM_TAPS  = 7;
	localparam int HALF_TAPS = 3;

	localparam logic [VAL_W-1:0] GAIN_ONE = 16'h8000;

	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_SMOOTH = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [7:0] TAP_W [NUM_TAPS] = '{8'd2, 8'd22, 8'd97, 8'd159, 8'd97, 8'd22, 8'd2};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PINIT,
		ST_STREAM,
		ST_DRAIN,
		ST_PEND
	} step_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_CLR_END,
		C_START,
		C_STREAM_END,
		C_PIPE_EMPTY,
		C_LAST_PASS
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  clr_wr;
		logic  cnt_zero;
		logic  cnt_inc;
		logic  stream;
		logic  win_clr;
		logic  pass_dec;
		cond_t cond;
		step_t go_t;
		step_t go_f;
	} uword_t;

	typedef struct packed {
		logic clr_wr;
		logic stream;
		logic win_clr;
	} seq_ctl_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [IDX_W-1:0]  index;
		logic [VAL_W-1:0]  value;
		logic [PASS_W-1:0] passes;
	} item_t;

	function automatic uword_t ucode_rom(step_t s);
		uword_t w;
		begin
			w = '0;
			case (s)
				ST_CLEAR: begin
					w.clr_wr  = 1'b1;
					w.cnt_inc = 1'b1;
					w.cond    = C_CLR_END;
					w.go_t    = ST_IDLE;
					w.go_f    = ST_CLEAR;
				end
				ST_IDLE: begin
					w.in_ready = 1'b1;
					w.cnt_zero = 1'b1;
					w.cond     = C_START;
					w.go_t     = ST_PINIT;
					w.go_f     = ST_IDLE;
				end
				ST_PINIT: begin
					w.cnt_zero = 1'b1;
					w.win_clr  = 1'b1;
					w.cond     = C_ALWAYS;
					w.go_t     = ST_STREAM;
					w.go_f     = ST_STREAM;
				end
				ST_STREAM: begin
					w.stream  = 1'b1;
					w.cnt_inc = 1'b1;
					w.cond    = C_STREAM_END;
					w.go_t    = ST_DRAIN;
					w.go_f    = ST_STREAM;
				end
				ST_DRAIN: begin
					w.cond = C_PIPE_EMPTY;
					w.go_t = ST_PEND;
					w.go_f = ST_DRAIN;
				end
				ST_PEND: begin
					w.pass_dec = 1'b1;
					w.cond     = C_LAST_PASS;
					w.go_t     = ST_IDLE;
					w.go_f     = ST_PINIT;
				end
				default: begin
					w.cond = C_ALWAYS;
					w.go_t = ST_IDLE;
					w.go_f = ST_IDLE;
				end
			endcase
			return w;
		end
	endfunction

	// ceil(2^RCP_SHIFT / d) for every divisor the window can produce
	function automatic logic [RCP_W-1:0] recip(logic [DIV_W-1:0] d);
		logic [RCP_W-1:0] r;
		begin
			case (d)
				9'd280:  r = 25'd30678338;
				9'd377:  r = 25'd22784973;
				9'd399:  r = 25'd21528659;
				default: r = 25'd21421284;
			endcase
			return r;
		end
	endfunction

	function automatic logic idx_in_range(logic [IDX_W-1:0] idx, int unsigned size);
		begin
			return (32'(idx) < size);
		end
	endfunction

endpackage

[sv/esf_in_if.sv]
// ----------------------------------------------------------------------------
// esf_in_if
// Input channel: action, index, value and pass count with valid/ready.
// ----------------------------------------------------------------------------
interface esf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [9:0]  index;
	logic [15:0] value;
	logic [7:0]  passes;

	modport source (output valid, output action, output index, output value, output passes,
		input ready);
	modport sink (input valid, input action, input index, input value, input passes,
		output ready);
endinterface

[sv/esf_out_if.sv]
// ----------------------------------------------------------------------------
// esf_out_if
// Result channel: read value with valid/ready.
// ----------------------------------------------------------------------------
interface esf_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_value;

	modport source (output valid, output read_value, input ready);
	modport sink (input valid, input read_value, output ready);
endinterface

[sv/esf_seq.sv]
// ----------------------------------------------------------------------------
// esf_seq
// Microcoded sequencer: step register, control ROM, element and pass counters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esf_seq #(
	parameter int ENV_DEPTH = 1024,
	parameter int CW        = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [7:0]           passes,
	input  logic                 pipe_empty,
	output logic                 in_ready,
	output esf_pkg::seq_ctl_t    ctl,
	output logic [CW-1:0]        cnt
);

	esf_pkg::uword_t uw;
	esf_pkg::step_t  upc_q;
	esf_pkg::step_t  upc_d;
	logic [CW-1:0]   cnt_q;
	logic [7:0]      pass_q;
	logic            hit;

	always_comb begin
		uw = esf_pkg::ucode_rom(upc_q);
		case (uw.cond)
			esf_pkg::C_ALWAYS:     hit = 1'b1;
			esf_pkg::C_CLR_END:    hit = (cnt_q == CW'(ENV_DEPTH - 1));
			esf_pkg::C_START:      hit = start;
			esf_pkg::C_STREAM_END: hit = (cnt_q == CW'(ENV_DEPTH + 2));
			esf_pkg::C_PIPE_EMPTY: hit = pipe_empty;
			esf_pkg::C_LAST_PASS:  hit = (pass_q == 8'd1);
			default:               hit = 1'b1;
		endcase
		upc_d = hit ? uw.go_t : uw.go_f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= esf_pkg::ST_CLEAR;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pass_q <= '0;
		end else begin
			if (uw.cnt_zero) begin
				cnt_q <= '0;
			end else if (uw.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (uw.in_ready && start) begin
				pass_q <= passes;
			end else if (uw.pass_dec) begin
				pass_q <= pass_q - 8'd1;
			end
		end
	end

	assign in_ready    = uw.in_ready;
	assign ctl.clr_wr  = uw.clr_wr;
	assign ctl.stream  = uw.stream;
	assign ctl.win_clr = uw.win_clr;
	assign cnt         = cnt_q;

	`ESF_ASSERT(a_pass_live, clk, arst_n, uw.stream |-> (pass_q != 8'd0))
	`ESF_ASSERT(a_cnt_bound, clk, arst_n, uw.stream |-> (cnt_q <= CW'(ENV_DEPTH + 2)))
	`ESF_ASSERT(a_idle_drained, clk, arst_n, uw.in_ready |-> pipe_empty)
	`ESF_ASSERT_NR(a_ctl_excl, clk, !(uw.clr_wr && uw.stream))

endmodule

[sv/esf_dp.sv]
// ----------------------------------------------------------------------------
// esf_dp
// Datapath: envelope memory, 7-tap window, weighted sum and reciprocal divide.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esf_dp #(
	parameter int ENV_DEPTH = 1024,
	parameter int AW        = 10,
	parameter int CW        = 11
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  esf_pkg::seq_ctl_t              ctl,
	input  logic [CW-1:0]                  cnt,
	input  logic                           item_acc,
	input  esf_pkg::item_t                 item,
	output logic [esf_pkg::VAL_W-1:0]      rdata,
	output logic                           pipe_empty
);

	logic [esf_pkg::VAL_W-1:0] mem_q [ENV_DEPTH];
	logic [esf_pkg::VAL_W-1:0] rdata_q;

	logic                      in_rng;
	logic                      item_wr;
	logic                      item_rd;
	logic [esf_pkg::VAL_W-1:0] item_val;
	logic                      elem_now;
	logic                      emit_now;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [esf_pkg::VAL_W-1:0] wr_data;

	logic                      live_s1, elem_s1, emit_s1;
	logic [AW-1:0]             widx_s1;
	logic                      live_s2;
	logic [AW-1:0]             widx_s2;
	logic                      live_s3;
	logic [AW-1:0]             widx_s3;
	logic [esf_pkg::ACC_W-1:0] num_s3;
	logic [esf_pkg::RCP_W-1:0] rcp_s3;
	logic                      live_s4;
	logic [AW-1:0]             widx_s4;
	logic [esf_pkg::PROD_W-1:0] prod_s4;

	logic [esf_pkg::VAL_W-1:0] win_q [esf_pkg::NUM_TAPS];
	logic [esf_pkg::NUM_TAPS-1:0] winv_q;

	logic [esf_pkg::ACC_W-1:0] sum_c;
	logic [esf_pkg::DIV_W-1:0] div_c;
	logic [esf_pkg::VAL_W-1:0] quo;
	logic [esf_pkg::VAL_W-1:0] wb_val;

	always_comb begin
		in_rng   = esf_pkg::idx_in_range(item.index, ENV_DEPTH);
		item_wr  = item_acc && (item.action == esf_pkg::ACT_WRITE) && in_rng;
		item_rd  = item_acc && (item.action == esf_pkg::ACT_READ) && in_rng;
		item_val = (item.value > esf_pkg::GAIN_ONE) ? esf_pkg::GAIN_ONE : item.value;
		elem_now = ctl.stream && (cnt < CW'(ENV_DEPTH));
		emit_now = ctl.stream && (cnt >= CW'(esf_pkg::HALF_TAPS));
		rd_en    = item_rd || elem_now;
		rd_addr  = elem_now ? AW'(cnt) : AW'(item.index);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(item.index);
		wr_data = item_val;
		if (ctl.clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = AW'(cnt);
			wr_data = esf_pkg::GAIN_ONE;
		end else if (live_s4) begin
			wr_en   = 1'b1;
			wr_addr = widx_s4;
			wr_data = wb_val;
		end else if (item_wr) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1 <= 1'b0;
			elem_s1 <= 1'b0;
			emit_s1 <= 1'b0;
			live_s2 <= 1'b0;
			live_s3 <= 1'b0;
			live_s4 <= 1'b0;
			winv_q  <= '0;
		end else begin
			live_s1 <= ctl.stream;
			elem_s1 <= elem_now;
			emit_s1 <= emit_now;
			live_s2 <= live_s1 && emit_s1;
			live_s3 <= live_s2;
			live_s4 <= live_s3;
			if (ctl.win_clr) begin
				winv_q <= '0;
			end else if (live_s1) begin
				winv_q <= {elem_s1, winv_q[esf_pkg::NUM_TAPS-1:1]};
			end
		end
	end

	// window shift: newest tap enters at the top
	always_ff @(posedge clk) begin
		if (live_s1) begin
			for (int j = 0; j < esf_pkg::NUM_TAPS - 1; j++) begin
				win_q[j] <= win_q[j+1];
			end
			win_q[esf_pkg::NUM_TAPS-1] <= rdata_q;
		end
	end

	always_comb begin
		sum_c = '0;
		div_c = '0;
		for (int j = 0; j < esf_pkg::NUM_TAPS; j++) begin
			if (winv_q[j]) begin
				sum_c = sum_c + esf_pkg::ACC_W'(win_q[j]) * esf_pkg::ACC_W'(esf_pkg::TAP_W[j]);
				div_c = div_c + esf_pkg::DIV_W'(esf_pkg::TAP_W[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		widx_s1 <= AW'(cnt - CW'(esf_pkg::HALF_TAPS));
		widx_s2 <= widx_s1;
		widx_s3 <= widx_s2;
		num_s3  <= sum_c + esf_pkg::ACC_W'(div_c >> 1);
		rcp_s3  <= esf_pkg::recip(div_c);
		widx_s4 <= widx_s3;
		prod_s4 <= esf_pkg::PROD_W'(num_s3) * esf_pkg::PROD_W'(rcp_s3);
	end

	always_comb begin
		quo    = prod_s4[esf_pkg::RCP_SHIFT +: esf_pkg::VAL_W];
		wb_val = (quo > esf_pkg::GAIN_ONE) ? esf_pkg::GAIN_ONE : quo;
	end

	assign rdata      = rdata_q;
	assign pipe_empty = !(live_s1 || live_s2 || live_s3 || live_s4);

	`ESF_ASSERT(a_wr_excl, clk, arst_n, $onehot0({ctl.clr_wr, live_s4, item_wr}))
	`ESF_ASSERT(a_wb_range, clk, arst_n, live_s4 |-> (wb_val <= esf_pkg::GAIN_ONE))
	`ESF_ASSERT(a_item_quiet, clk, arst_n, item_acc |-> (pipe_empty && !ctl.stream))

endmodule

[sv/envelope_smoothing_filter_unit.sv]
// ----------------------------------------------------------------------------
// envelope_smoothing_filter_unit
// Envelope of ENV_DEPTH Q1.15 gains (32768 = 1.0) with write, read and
// 7-tap smoothing (2,22,97,159,97,22,2) that drops taps off either end from
// both the sum and the divisor, rounds to nearest and saturates at one.
// After reset the block sweeps the envelope to one with input ready low.
// Write and read transactions are taken one per cycle unless the output
// stalls; a read result passes the memory read register and the output
// register. A smooth transaction returns its zero result at once and then
// holds input ready low for its passes: each pass streams every element
// once through the single memory read port, with the new values written
// back in place behind the window, plus a short drain of the divide pipeline.
// ----------------------------------------------------------------------------
module envelope_smoothing_filter_unit #(
	parameter int ENV_DEPTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	esf_in_if.sink     in_ch,
	esf_out_if.source  out_ch
);

	localparam int AW = $clog2(ENV_DEPTH);
	localparam int CW = $clog2(ENV_DEPTH + 3);

	esf_pkg::item_t            item;
	esf_pkg::seq_ctl_t         ctl;
	logic [CW-1:0]             cnt;
	logic                      seq_ready;
	logic                      pipe_empty;
	logic                      accept;
	logic                      start;
	logic                      pend_move;
	logic [esf_pkg::VAL_W-1:0] rdata;

	logic                      pend_s1;
	logic                      pend_rd_s1;
	logic                      out_valid_q;
	logic [esf_pkg::VAL_W-1:0] out_data_q;

	always_comb begin
		item.action = in_ch.action;
		item.index  = in_ch.index;
		item.value  = in_ch.value;
		item.passes = in_ch.passes;
		pend_move   = pend_s1 && (!out_valid_q || out_ch.ready);
		in_ch.ready = seq_ready && (!pend_s1 || pend_move);
		accept      = in_ch.valid && in_ch.ready;
		start       = accept && (in_ch.action == esf_pkg::ACT_SMOOTH) && (in_ch.passes != 8'd0);
	end

	esf_seq #(
		.ENV_DEPTH  (ENV_DEPTH),
		.CW         (CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.passes     (in_ch.passes),
		.pipe_empty (pipe_empty),
		.in_ready   (seq_ready),
		.ctl        (ctl),
		.cnt        (cnt)
	);

	esf_dp #(
		.ENV_DEPTH  (ENV_DEPTH),
		.AW         (AW),
		.CW         (CW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cnt        (cnt),
		.item_acc   (accept),
		.item       (item),
		.rdata      (rdata),
		.pipe_empty (pipe_empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pend_s1 <= 1'b1;
			end else if (pend_move) begin
				pend_s1 <= 1'b0;
			end
			if (pend_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_rd_s1 <= (in_ch.action == esf_pkg::ACT_READ) &&
				esf_pkg::idx_in_range(in_ch.index, ENV_DEPTH);
		end
		if (pend_move) begin
			out_data_q <= pend_rd_s1 ? rdata : '0;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.read_value = out_data_q;

endmodule
